// File: rtl/amb_pkg.sv
// Shared types, constants and register codes of the audio meter ballistics unit.
// No dependencies; the config registers, core and top refer to it by scoped names.
`default_nettype none

package amb_pkg;

	localparam int AMB_NUM_CHANNELS = 8;

	localparam logic signed [15:0] NEG_INF = 16'sh8000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;

	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_HOLD_TIME  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HOLD_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM_LEVEL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT    = 3'd5;

	localparam logic [15:0]        DECAY_RATE_RST      = 16'd3157;
	localparam logic [15:0]        MAGNITUDE_GAIN_RST  = 16'd886;
	localparam logic [25:0]        PEAK_HOLD_TIME_RST  = 26'd20000000;
	localparam logic [25:0]        INPUT_HOLD_TIME_RST = 26'd1000000;
	localparam logic signed [15:0] MINIMUM_LEVEL_RST   = -16'sd15360;
	localparam logic [25:0]        IDLE_TIMEOUT_RST    = 26'd500000;

	localparam logic [17:0] DECAY_SAT = 18'h20000;
	localparam logic [44:0] T_SAT     = 45'h1000_0000_0000;

	typedef struct packed {
		logic [15:0]        decay_rate;
		logic [15:0]        magnitude_gain;
		logic [25:0]        peak_hold_time;
		logic [25:0]        input_hold_time;
		logic signed [15:0] minimum_level;
		logic [25:0]        idle_timeout;
	} amb_cfg_t;

	typedef struct packed {
		logic               op;
		logic [2:0]         channel;
		logic signed [15:0] magnitude;
		logic signed [15:0] peak;
		logic signed [15:0] input_peak;
		logic               last_channel;
		logic [31:0]        time_us;
	} amb_req_t;

	typedef struct packed {
		logic [2:0]         out_channel;
		logic signed [15:0] shown_magnitude;
		logic signed [15:0] shown_peak;
		logic signed [15:0] shown_peak_hold;
		logic signed [15:0] shown_input_hold;
		logic               idle;
		logic               last;
	} amb_rsp_t;

	typedef struct packed {
		logic signed [15:0] mag;
		logic signed [15:0] peak;
		logic signed [15:0] ipeak;
	} amb_cur_t;

	typedef struct packed {
		logic signed [15:0] mag;
		logic signed [15:0] peak;
		logic signed [15:0] phold;
		logic signed [15:0] ihold;
		logic [31:0]        pstamp;
		logic [31:0]        istamp;
	} amb_disp_t;

	localparam amb_cur_t CUR_RESET = '{mag: NEG_INF, peak: NEG_INF, ipeak: NEG_INF};

	localparam amb_disp_t DISP_RESET = '{
		mag: NEG_INF, peak: NEG_INF, phold: NEG_INF, ihold: NEG_INF,
		pstamp: 32'd0, istamp: 32'd0
	};

endpackage

`default_nettype wire

// File: rtl/amb_stream_if.sv
// Valid/ready stream channel carrying one request or result per handshake.
// Payload type is a parameter; no dependencies.
`default_nettype none

interface amb_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/amb_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module amb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/amb_cfg_regs.sv
// Configuration register file of the meter ballistics unit.
// Depends on amb_pkg for register codes, reset values and amb_cfg_t.
`default_nettype none

module amb_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [amb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [amb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output amb_pkg::amb_cfg_t               cfg
);

	amb_pkg::amb_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay_rate      <= amb_pkg::DECAY_RATE_RST;
			cfg_q.magnitude_gain  <= amb_pkg::MAGNITUDE_GAIN_RST;
			cfg_q.peak_hold_time  <= amb_pkg::PEAK_HOLD_TIME_RST;
			cfg_q.input_hold_time <= amb_pkg::INPUT_HOLD_TIME_RST;
			cfg_q.minimum_level   <= amb_pkg::MINIMUM_LEVEL_RST;
			cfg_q.idle_timeout    <= amb_pkg::IDLE_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				amb_pkg::CFG_DECAY_RATE:      cfg_q.decay_rate      <= cfg_wdata[15:0];
				amb_pkg::CFG_MAGNITUDE_GAIN:  cfg_q.magnitude_gain  <= cfg_wdata[15:0];
				amb_pkg::CFG_PEAK_HOLD_TIME:  cfg_q.peak_hold_time  <= cfg_wdata;
				amb_pkg::CFG_INPUT_HOLD_TIME: cfg_q.input_hold_time <= cfg_wdata;
				amb_pkg::CFG_MINIMUM_LEVEL:   cfg_q.minimum_level   <= $signed(cfg_wdata[15:0]);
				amb_pkg::CFG_IDLE_TIMEOUT:    cfg_q.idle_timeout    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/amb_core.sv
// Sequencer and per-channel ballistics datapath: read-modify-write over the
// level and display memories. Depends on amb_pkg and amb_stream_if.
`default_nettype none

module amb_core #(
	parameter int NUM_CHANNELS = amb_pkg::AMB_NUM_CHANNELS,
	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  amb_pkg::amb_cfg_t    cfg,
	amb_stream_if.sink           req,
	amb_stream_if.source         rsp,
	output logic                 cur_we,
	output logic [AW-1:0]        cur_waddr,
	output amb_pkg::amb_cur_t    cur_wdata,
	output logic                 disp_we,
	output logic [AW-1:0]        disp_waddr,
	output amb_pkg::amb_disp_t   disp_wdata,
	output logic [AW-1:0]        rd_addr,
	input  amb_pkg::amb_cur_t    cur_rdata,
	input  amb_pkg::amb_disp_t   disp_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELAPSED,
		ST_DPROD,
		ST_TPROD,
		ST_TSAT,
		ST_READ,
		ST_CALC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_WB
	} state_t;

	state_t state_q;

	logic [AW-1:0]           ch_q;
	logic                    op_q;
	logic                    idle_q;
	logic [31:0]             ts_q;
	logic [31:0]             elapsed_q;
	logic [31:0]             last_update_q;
	logic [31:0]             last_redraw_q;
	logic [47:0]             prod_q;
	logic [17:0]             d_q;
	logic [44:0]             t_q;
	logic [NUM_CHANNELS-1:0] cur_vld_q;
	logic [NUM_CHANNELS-1:0] disp_vld_q;
	logic                    cvld_q;
	logic                    dvld_q;

	logic signed [15:0]      npk_q;
	logic signed [15:0]      nph_q;
	logic signed [15:0]      nih_q;
	logic signed [15:0]      dmag_q;
	logic signed [15:0]      cmag_q;
	logic [31:0]             pstamp_q;
	logic [31:0]             istamp_q;
	logic                    copy_q;
	logic                    neg_q;
	logic [15:0]             ad_q;
	logic [37:0]             plo_q;
	logic [38:0]             phi_q;
	logic [17:0]             a_q;

	amb_pkg::amb_rsp_t       rsp_q;
	logic                    rsp_valid_q;

	logic                    req_fire;
	logic                    ch_ok;
	logic                    idle_hit;
	logic [31:0]             elapsed_next;
	logic [17:0]             d_next;
	logic [44:0]             t_next;
	amb_pkg::amb_cur_t       cur_eff;
	amb_pkg::amb_disp_t      disp_eff;
	logic signed [15:0]      c_mag, c_pk, c_ipk, d_mag, d_pk, d_ph, d_ih;
	logic signed [18:0]      pk_x;
	logic signed [15:0]      npk;
	logic                    ph_take;
	logic                    ih_take;
	logic signed [16:0]      diff;
	logic [60:0]             full_prod;
	logic [32:0]             a_raw;
	logic [17:0]             a_next;
	logic signed [18:0]      mx;
	logic signed [18:0]      min19;
	logic signed [15:0]      nmag;
	logic                    wb_go;
	logic                    last_ch;
	amb_pkg::amb_rsp_t       rsp_next;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign ch_ok     = {29'd0, req.payload.channel} < 32'(NUM_CHANNELS);

	always_comb begin
		cur_we          = req_fire && !req.payload.op && ch_ok;
		cur_waddr       = AW'(req.payload.channel);
		cur_wdata.mag   = req.payload.magnitude;
		cur_wdata.peak  = req.payload.peak;
		cur_wdata.ipeak = req.payload.input_peak;
	end

	assign rd_addr = ch_q;

	assign idle_hit     = op_q && ((ts_q - last_update_q) > {6'd0, cfg.idle_timeout});
	assign elapsed_next = op_q ? (ts_q - last_redraw_q) : 32'd0;
	assign d_next       = (prod_q[47:20] > 28'(amb_pkg::DECAY_SAT)) ? amb_pkg::DECAY_SAT
	                                                               : prod_q[37:20];
	assign t_next       = (prod_q > 48'(amb_pkg::T_SAT)) ? amb_pkg::T_SAT : prod_q[44:0];

	// never-written entries read as the reset state
	always_comb begin
		cur_eff  = cvld_q ? cur_rdata : amb_pkg::CUR_RESET;
		disp_eff = dvld_q ? disp_rdata : amb_pkg::DISP_RESET;
		c_mag    = cur_eff.mag;
		c_pk     = cur_eff.peak;
		c_ipk    = cur_eff.ipeak;
		d_mag    = disp_eff.mag;
		d_pk     = disp_eff.peak;
		d_ph     = disp_eff.phold;
		d_ih     = disp_eff.ihold;
	end

	// peak: instant attack, linear decay clamped to [current, 0]
	always_comb begin
		pk_x = 19'(d_pk) - $signed({1'b0, d_q});
		if (c_pk >= d_pk) begin
			npk = c_pk;
		end else if (pk_x < 19'(c_pk)) begin
			npk = c_pk;
		end else if (pk_x > 19'sd0) begin
			npk = 16'sd0;
		end else begin
			npk = pk_x[15:0];
		end
	end

	assign ph_take = (c_pk >= d_ph) || (d_ph == amb_pkg::NEG_INF)
	                 || ((ts_q - disp_eff.pstamp) > {6'd0, cfg.peak_hold_time});
	assign ih_take = (c_ipk >= d_ih) || (d_ih == amb_pkg::NEG_INF)
	                 || ((ts_q - disp_eff.istamp) > {6'd0, cfg.input_hold_time});
	assign diff    = 17'(c_mag) - 17'(d_mag);

	assign full_prod = {phi_q, 22'd0} + {23'd0, plo_q};
	assign a_raw     = full_prod[60:28];
	assign a_next    = (a_raw > 33'(amb_pkg::DECAY_SAT)) ? amb_pkg::DECAY_SAT : a_raw[17:0];

	always_comb begin
		min19 = 19'(cfg.minimum_level);
		if (neg_q) begin
			mx = 19'(dmag_q) - $signed({1'b0, a_q});
		end else begin
			mx = 19'(dmag_q) + $signed({1'b0, a_q});
		end
		if (copy_q) begin
			nmag = cmag_q;
		end else if (mx < min19) begin
			nmag = cfg.minimum_level;
		end else if (mx > 19'sd0) begin
			nmag = 16'sd0;
		end else begin
			nmag = mx[15:0];
		end
	end

	assign last_ch = (ch_q == AW'(NUM_CHANNELS - 1));
	assign wb_go   = (state_q == ST_WB) && (!op_q || !rsp_valid_q || rsp.ready);

	always_comb begin
		disp_we           = wb_go && !idle_q;
		disp_waddr        = ch_q;
		disp_wdata.mag    = nmag;
		disp_wdata.peak   = npk_q;
		disp_wdata.phold  = nph_q;
		disp_wdata.ihold  = nih_q;
		disp_wdata.pstamp = pstamp_q;
		disp_wdata.istamp = istamp_q;

		rsp_next.out_channel      = 3'(ch_q);
		rsp_next.shown_magnitude  = idle_q ? amb_pkg::NEG_INF : nmag;
		rsp_next.shown_peak       = idle_q ? amb_pkg::NEG_INF : npk_q;
		rsp_next.shown_peak_hold  = idle_q ? amb_pkg::NEG_INF : nph_q;
		rsp_next.shown_input_hold = idle_q ? amb_pkg::NEG_INF : nih_q;
		rsp_next.idle             = idle_q;
		rsp_next.last             = last_ch;
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ch_q          <= '0;
			op_q          <= 1'b0;
			idle_q        <= 1'b0;
			last_update_q <= 32'd0;
			last_redraw_q <= 32'd0;
			cur_vld_q     <= '0;
			disp_vld_q    <= '0;
			cvld_q        <= 1'b0;
			dvld_q        <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (wb_go && op_q) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_next;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (cur_we) begin
				cur_vld_q[cur_waddr] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.payload.op || req.payload.last_channel)) begin
						op_q    <= req.payload.op;
						ts_q    <= req.payload.time_us;
						if (!req.payload.op) begin
							last_update_q <= req.payload.time_us;
						end
						state_q <= ST_ELAPSED;
					end
				end
				ST_ELAPSED: begin
					elapsed_q <= elapsed_next;
					idle_q    <= idle_hit;
					if (op_q) begin
						last_redraw_q <= ts_q;
					end
					// idle timeout: level and display state back to reset, this pass writes nothing
					if (idle_hit) begin
						last_update_q <= 32'd0;
						cur_vld_q     <= '0;
						disp_vld_q    <= '0;
					end
					state_q <= ST_DPROD;
				end
				ST_DPROD: begin
					prod_q  <= {32'd0, cfg.decay_rate} * {16'd0, elapsed_q};
					state_q <= ST_TPROD;
				end
				ST_TPROD: begin
					prod_q  <= {32'd0, cfg.magnitude_gain} * {16'd0, elapsed_q};
					d_q     <= d_next;
					state_q <= ST_TSAT;
				end
				ST_TSAT: begin
					t_q     <= t_next;
					ch_q    <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					cvld_q  <= cur_vld_q[ch_q];
					dvld_q  <= disp_vld_q[ch_q];
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					npk_q    <= npk;
					nph_q    <= ph_take ? c_pk : d_ph;
					pstamp_q <= ph_take ? ts_q : disp_eff.pstamp;
					nih_q    <= ih_take ? c_ipk : d_ih;
					istamp_q <= ih_take ? ts_q : disp_eff.istamp;
					copy_q   <= (d_mag == amb_pkg::NEG_INF);
					neg_q    <= diff[16];
					ad_q     <= diff[16] ? 16'(-diff) : diff[15:0];
					dmag_q   <= d_mag;
					cmag_q   <= c_mag;
					state_q  <= ST_MUL_LO;
				end
				ST_MUL_LO: begin
					plo_q   <= {22'd0, ad_q} * {16'd0, t_q[21:0]};
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					phi_q   <= {23'd0, ad_q} * {16'd0, t_q[44:22]};
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					a_q     <= a_next;
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_go) begin
						if (disp_we) begin
							disp_vld_q[ch_q] <= 1'b1;
						end
						if (last_ch) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELAPSED && idle_hit) |=> (cur_vld_q == '0 && disp_vld_q == '0))
		else $error("idle timeout did not clear the level state");

	a_pass_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_go && last_ch) |=> (state_q == ST_IDLE))
		else $error("pass did not end after the last channel");

	a_plain_level: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && !req.payload.op && !req.payload.last_channel) |=> (state_q == ST_IDLE))
		else $error("plain level request started a pass");

	a_sat_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (d_q <= amb_pkg::DECAY_SAT && t_q <= amb_pkg::T_SAT))
		else $error("decay step or integration factor out of range");

	a_rsp_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_go && op_q && rsp_next.last) |-> (ch_q == AW'(NUM_CHANNELS - 1)))
		else $error("last flag on wrong channel");
`endif

endmodule

`default_nettype wire

// File: rtl/audio_meter_ballistics_unit.sv
// Audio meter ballistics unit: per-channel peak/hold/integrating meter.
// Depends on amb_pkg, amb_stream_if, amb_ram, amb_cfg_regs and amb_core.
//
// Usage:
//   req carries level requests (op 0) and redraw ticks (op 1); rsp carries one
//   result per channel for each redraw, channel 0 first, last set on the final
//   one. Registers are to be written through cfg_we/cfg_idx/cfg_wdata only
//   while idle; the block itself does not enforce this. A level request without
//   last_channel is written to the level memory and the block stays ready. A
//   level request with last_channel, or a redraw, starts a pass, and no request
//   is taken until it ends: setup steps for the elapsed time and its two
//   products, then per channel a read, update, two partial products, sum and
//   write back on one shared datapath against the level and display memories.
//   A result waits in an output register; while rsp stalls the pass holds at
//   its write-back step. After the last result the next request is taken even
//   if that result is still waiting. Reset (arst_n low) restores register
//   defaults and marks every memory entry as unwritten, so all levels read as
//   minus infinity; no clearing pass.
`default_nettype none

module audio_meter_ballistics_unit #(
	parameter int NUM_CHANNELS = amb_pkg::AMB_NUM_CHANNELS,
	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [amb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [amb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	amb_stream_if.sink                      req,
	amb_stream_if.source                    rsp
);

	amb_pkg::amb_cfg_t  cfg;
	logic               cur_we;
	logic [AW-1:0]      cur_waddr;
	amb_pkg::amb_cur_t  cur_wdata;
	amb_pkg::amb_cur_t  cur_rdata;
	logic               disp_we;
	logic [AW-1:0]      disp_waddr;
	amb_pkg::amb_disp_t disp_wdata;
	amb_pkg::amb_disp_t disp_rdata;
	logic [AW-1:0]      rd_addr;

	amb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	amb_ram #(
		.WIDTH ($bits(amb_pkg::amb_cur_t)),
		.DEPTH (NUM_CHANNELS)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (rd_addr),
		.rdata (cur_rdata)
	);

	amb_ram #(
		.WIDTH ($bits(amb_pkg::amb_disp_t)),
		.DEPTH (NUM_CHANNELS)
	) u_disp_ram (
		.clk   (clk),
		.we    (disp_we),
		.waddr (disp_waddr),
		.wdata (disp_wdata),
		.raddr (rd_addr),
		.rdata (disp_rdata)
	);

	amb_core #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.rsp        (rsp),
		.cur_we     (cur_we),
		.cur_waddr  (cur_waddr),
		.cur_wdata  (cur_wdata),
		.disp_we    (disp_we),
		.disp_waddr (disp_waddr),
		.disp_wdata (disp_wdata),
		.rd_addr    (rd_addr),
		.cur_rdata  (cur_rdata),
		.disp_rdata (disp_rdata)
	);

endmodule

`default_nettype wire
